[design/lcws_pkg.sv]
package lcws_pkg;

   // history ring
   localparam int HIST_DEPTH = 10;
   localparam int HIST_AW    = $clog2(HIST_DEPTH);
   localparam int FILL_W     = $clog2(HIST_DEPTH + 1);

   // field widths
   localparam int WEIGHT_FRAC_BITS = 16;
   localparam int RAW_W    = 24;
   localparam int TARE_W   = 24;
   localparam int NET_W    = 25;
   localparam int SCALE_W  = 32;
   localparam int WEIGHT_W = 32;
   localparam int THR_W    = 31;
   localparam int WLEN_W   = 4;
   localparam int BIT_W    = $clog2(WLEN_W);

   // arithmetic widths
   localparam int MUL_W   = 36;
   localparam int PROD_W  = 2 * MUL_W;
   localparam int SUM_W   = 36;
   localparam int SQSUM_W = 68;
   localparam int ACC_W   = 72;
   localparam int TM_W    = THR_W + WLEN_W;

   // register port
   localparam int CSR_AW = 4;
   localparam int CSR_DW = 32;

   // reset values
   localparam logic signed [TARE_W-1:0]  TARE_RST  = '0;
   localparam logic signed [SCALE_W-1:0] SCALE_RST = SCALE_W'(1) << WEIGHT_FRAC_BITS;
   localparam logic [THR_W-1:0]          THR_RST   = THR_W'(2) << WEIGHT_FRAC_BITS;
   localparam logic [WLEN_W-1:0]         WLEN_RST  = WLEN_W'(5);

   // weight clamp limits
   localparam logic signed [PROD_W-1:0] WEIGHT_MAX =
      {{(PROD_W-WEIGHT_W+1){1'b0}}, {(WEIGHT_W-1){1'b1}}};
   localparam logic signed [PROD_W-1:0] WEIGHT_MIN =
      {{(PROD_W-WEIGHT_W+1){1'b1}}, {(WEIGHT_W-1){1'b0}}};

   typedef enum logic [CSR_AW-3:0] {
      CSR_TARE   = 2'd0,
      CSR_SCALE  = 2'd1,
      CSR_THRESH = 2'd2,
      CSR_WLEN   = 2'd3
   } csr_index_type;

   typedef enum logic {
      CMD_SAMPLE = 1'b0,
      CMD_CLEAR  = 1'b1
   } command_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_WEIGHT,
      ST_SATURATE,
      ST_MUL_LIMIT,
      ST_SCAN,
      ST_MUL_SUM,
      ST_SCALE_SUMSQ,
      ST_FINISH
   } seq_state_type;

endpackage

[design/lcws_if.sv]
interface lcws_req_if;
   import lcws_pkg::*;

   logic             valid;
   logic             ready;
   logic             command;
   logic [RAW_W-1:0] raw_code;

   modport source (output valid, command, raw_code, input ready);
   modport sink   (input valid, command, raw_code, output ready);
endinterface

interface lcws_rsp_if;
   import lcws_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [NET_W-1:0]    net_counts;
   logic signed [WEIGHT_W-1:0] weight;
   logic                       stable;

   modport source (output valid, net_counts, weight, stable, input ready);
   modport sink   (input valid, net_counts, weight, stable, output ready);
endinterface

[design/load_cell_weight_stability.sv]
// channel   | direction | word
// ----------+-----------+-----------------------------------------------
// req_ch    | in        | command, raw_code (24-bit converter code)
// rsp_ch    | out       | net_counts, weight (Q16.16), stable
// apb       | in/out    | tare_offset, scale_reciprocal, threshold, window
//
// a sample with a full window runs the shared 36x36 multiplier over the
// window one stored weight per cycle, plus a 4-step shift-add for the window
// scale; a sample whose window is not full skips the window scan, and a
// clear word only resets the history write position and fill count
// reset is synchronous; it empties the history and restores register defaults
// rsp has its own output register, so a new word is taken while a result waits;
// the sequencer only holds in its last step if the previous result is still unread
module load_cell_weight_stability (
   input  logic                           clock,
   input  logic                           reset,
   lcws_req_if.sink                       req_ch,
   lcws_rsp_if.source                     rsp_ch,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [lcws_pkg::CSR_AW-1:0]    paddr,
   input  logic [lcws_pkg::CSR_DW-1:0]    pwdata,
   output logic [lcws_pkg::CSR_DW-1:0]    prdata,
   output logic                           pready
);
   import lcws_pkg::*;

   // sequencer
   seq_state_type state_ff, state_in;

   // configuration registers
   logic signed [TARE_W-1:0]  tare_ff, tare_in;
   logic signed [SCALE_W-1:0] scale_ff, scale_in;
   logic [THR_W-1:0]          thr_ff, thr_in;
   logic [WLEN_W-1:0]         wlen_ff, wlen_in;

   // ring bookkeeping
   logic [HIST_AW-1:0] wr_pos_ff, wr_pos_in;
   logic [FILL_W-1:0]  fill_ff, fill_in;

   // per-sample working registers
   logic signed [NET_W-1:0]    net_ff, net_in;
   logic [TM_W-1:0]            tm_ff, tm_in;
   logic                       check_ff, check_in;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic signed [WEIGHT_W-1:0] weight_ff, weight_in;
   logic [ACC_W-1:0]           limit_ff, limit_in;
   logic signed [SUM_W-1:0]    sum_ff, sum_in;
   logic [SQSUM_W-1:0]         sumsq_ff, sumsq_in;
   logic [ACC_W-1:0]           mterm_ff, mterm_in;
   logic [HIST_AW-1:0]         rd_addr_ff, rd_addr_in;
   logic [WLEN_W-1:0]          rd_cnt_ff, rd_cnt_in;
   logic [BIT_W-1:0]           bit_cnt_ff, bit_cnt_in;
   logic                       rd_vld_ff, rd_vld_in;
   logic                       sq_vld_ff, sq_vld_in;

   // result register
   logic                       rsp_vld_ff, rsp_vld_in;
   logic signed [NET_W-1:0]    rsp_net_ff, rsp_net_in;
   logic signed [WEIGHT_W-1:0] rsp_weight_ff, rsp_weight_in;
   logic                       rsp_stable_ff, rsp_stable_in;

   // weight history memory
   logic signed [WEIGHT_W-1:0] hist_mem [HIST_DEPTH];
   logic signed [WEIGHT_W-1:0] rd_data_ff;
   logic                       mem_we;

   // shared multiplier
   logic signed [MUL_W-1:0]  mul_a, mul_b;
   logic signed [PROD_W-1:0] mul_p;

   logic             csr_wr;
   logic             stable_c;
   logic [HIST_AW:0] start_sum;
   logic [HIST_AW-1:0] start_addr;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   assign req_ch.ready      = (state_ff == ST_IDLE);
   assign rsp_ch.valid      = rsp_vld_ff;
   assign rsp_ch.net_counts = rsp_net_ff;
   assign rsp_ch.weight     = rsp_weight_ff;
   assign rsp_ch.stable     = rsp_stable_ff;

   // oldest entry of the window: write position minus window length, wrapped
   assign start_sum  = (HIST_AW+1)'(wr_pos_ff) + (HIST_AW+1)'(HIST_DEPTH)
                     - (HIST_AW+1)'(wlen_ff);
   assign start_addr = (start_sum >= (HIST_AW+1)'(HIST_DEPTH))
                     ? HIST_AW'(start_sum - (HIST_AW+1)'(HIST_DEPTH))
                     : HIST_AW'(start_sum);

   // m*sum(w^2) - (sum w)^2 <= (m*thr)^2, rearranged to avoid a subtract
   assign stable_c = check_ff
                  && (mterm_ff <= limit_ff + ACC_W'(unsigned'(prod_ff)));

   // operand select for the one multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_MUL_WEIGHT: begin
            mul_a = MUL_W'(net_ff);
            mul_b = MUL_W'(scale_ff);
         end
         ST_MUL_LIMIT: begin
            mul_a = MUL_W'(signed'({1'b0, tm_ff}));
            mul_b = MUL_W'(signed'({1'b0, tm_ff}));
         end
         ST_SCAN: begin
            mul_a = MUL_W'(rd_data_ff);
            mul_b = MUL_W'(rd_data_ff);
         end
         ST_MUL_SUM: begin
            mul_a = MUL_W'(sum_ff);
            mul_b = MUL_W'(sum_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // register read
   always_comb begin
      unique case (csr_index_type'(paddr[CSR_AW-1:2]))
         CSR_TARE:   prdata = CSR_DW'(tare_ff);
         CSR_SCALE:  prdata = CSR_DW'(scale_ff);
         CSR_THRESH: prdata = CSR_DW'(thr_ff);
         CSR_WLEN:   prdata = CSR_DW'(wlen_ff);
      endcase
   end

   // next state and datapath
   always_comb begin
      state_in      = state_ff;
      tare_in       = tare_ff;
      scale_in      = scale_ff;
      thr_in        = thr_ff;
      wlen_in       = wlen_ff;
      wr_pos_in     = wr_pos_ff;
      fill_in       = fill_ff;
      net_in        = net_ff;
      tm_in         = tm_ff;
      check_in      = check_ff;
      prod_in       = prod_ff;
      weight_in     = weight_ff;
      limit_in      = limit_ff;
      sum_in        = sum_ff;
      sumsq_in      = sumsq_ff;
      mterm_in      = mterm_ff;
      rd_addr_in    = rd_addr_ff;
      rd_cnt_in     = rd_cnt_ff;
      bit_cnt_in    = bit_cnt_ff;
      rd_vld_in     = rd_vld_ff;
      sq_vld_in     = sq_vld_ff;
      rsp_vld_in    = rsp_vld_ff && !rsp_ch.ready;
      rsp_net_in    = rsp_net_ff;
      rsp_weight_in = rsp_weight_ff;
      rsp_stable_in = rsp_stable_ff;
      mem_we        = 1'b0;

      // the user must write configuration only while the sequencer is idle; the block itself does not enforce this
      if (csr_wr) begin
         unique case (csr_index_type'(paddr[CSR_AW-1:2]))
            CSR_TARE:   tare_in  = pwdata[TARE_W-1:0];
            CSR_SCALE:  scale_in = pwdata[SCALE_W-1:0];
            CSR_THRESH: thr_in   = pwdata[THR_W-1:0];
            CSR_WLEN:   wlen_in  = pwdata[WLEN_W-1:0];
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               if (req_ch.command == CMD_CLEAR) begin
                  // entries past the fill count are never read, so no sweep
                  wr_pos_in = '0;
                  fill_in   = '0;
               end else begin
                  net_in     = NET_W'($signed(req_ch.raw_code)) - NET_W'(tare_ff);
                  tm_in      = TM_W'(thr_ff) * TM_W'(wlen_ff);
                  check_in   = (wlen_ff != '0) && (32'(wlen_ff) <= HIST_DEPTH)
                            && (32'(fill_ff) >= 32'(wlen_ff));
                  rd_addr_in = start_addr;
                  rd_cnt_in  = '0;
                  bit_cnt_in = '0;
                  sum_in     = '0;
                  sumsq_in   = '0;
                  mterm_in   = '0;
                  rd_vld_in  = 1'b0;
                  sq_vld_in  = 1'b0;
                  state_in   = ST_MUL_WEIGHT;
               end
            end
         end

         ST_MUL_WEIGHT: begin
            prod_in  = mul_p;
            state_in = ST_SATURATE;
         end

         ST_SATURATE: begin
            if (prod_ff > WEIGHT_MAX) begin
               weight_in = WEIGHT_MAX[WEIGHT_W-1:0];
            end else if (prod_ff < WEIGHT_MIN) begin
               weight_in = WEIGHT_MIN[WEIGHT_W-1:0];
            end else begin
               weight_in = prod_ff[WEIGHT_W-1:0];
            end
            state_in = check_ff ? ST_MUL_LIMIT : ST_FINISH;
         end

         ST_MUL_LIMIT: begin
            prod_in  = mul_p;
            state_in = ST_SCAN;
         end

         ST_SCAN: begin
            // first cycle: keep (m*thr)^2 before the squares overwrite it
            if (rd_cnt_ff == '0) begin
               limit_in = unsigned'(prod_ff);
            end
            // issue one read per cycle
            if (rd_cnt_ff < wlen_ff) begin
               rd_vld_in = 1'b1;
               rd_cnt_in = rd_cnt_ff + WLEN_W'(1);
               rd_addr_in = (rd_addr_ff == HIST_AW'(HIST_DEPTH - 1))
                          ? '0 : rd_addr_ff + HIST_AW'(1);
            end else begin
               rd_vld_in = 1'b0;
            end
            // square and sum the word read last cycle
            if (rd_vld_ff) begin
               prod_in   = mul_p;
               sum_in    = sum_ff + SUM_W'(rd_data_ff);
               sq_vld_in = 1'b1;
            end else begin
               sq_vld_in = 1'b0;
            end
            // accumulate the square
            if (sq_vld_ff) begin
               sumsq_in = sumsq_ff + prod_ff[SQSUM_W-1:0];
            end
            if ((rd_cnt_ff == wlen_ff) && !rd_vld_ff && !sq_vld_ff) begin
               state_in = ST_MUL_SUM;
            end
         end

         ST_MUL_SUM: begin
            prod_in  = mul_p;
            state_in = ST_SCALE_SUMSQ;
         end

         ST_SCALE_SUMSQ: begin
            // m * sum(w^2) by shift-add over the bits of m
            if (wlen_ff[bit_cnt_ff]) begin
               mterm_in = mterm_ff + (ACC_W'(sumsq_ff) << bit_cnt_ff);
            end
            bit_cnt_in = bit_cnt_ff + BIT_W'(1);
            if (bit_cnt_ff == BIT_W'(WLEN_W - 1)) begin
               state_in = ST_FINISH;
            end
         end

         ST_FINISH: begin
            if (!rsp_vld_ff || rsp_ch.ready) begin
               rsp_vld_in    = 1'b1;
               rsp_net_in    = net_ff;
               rsp_weight_in = weight_ff;
               rsp_stable_in = stable_c;
               mem_we        = 1'b1;
               wr_pos_in     = (wr_pos_ff == HIST_AW'(HIST_DEPTH - 1))
                             ? '0 : wr_pos_ff + HIST_AW'(1);
               fill_in       = (fill_ff == FILL_W'(HIST_DEPTH))
                             ? fill_ff : fill_ff + FILL_W'(1);
               state_in      = ST_IDLE;
            end
         end
      endcase
   end

   // history ring, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         hist_mem[wr_pos_ff] <= weight_ff;
      end
      rd_data_ff <= hist_mem[rd_addr_ff];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         tare_ff    <= TARE_RST;
         scale_ff   <= SCALE_RST;
         thr_ff     <= THR_RST;
         wlen_ff    <= WLEN_RST;
         wr_pos_ff  <= '0;
         fill_ff    <= '0;
         rd_vld_ff  <= 1'b0;
         sq_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         tare_ff    <= tare_in;
         scale_ff   <= scale_in;
         thr_ff     <= thr_in;
         wlen_ff    <= wlen_in;
         wr_pos_ff  <= wr_pos_in;
         fill_ff    <= fill_in;
         rd_vld_ff  <= rd_vld_in;
         sq_vld_ff  <= sq_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      net_ff        <= net_in;
      tm_ff         <= tm_in;
      check_ff      <= check_in;
      prod_ff       <= prod_in;
      weight_ff     <= weight_in;
      limit_ff      <= limit_in;
      sum_ff        <= sum_in;
      sumsq_ff      <= sumsq_in;
      mterm_ff      <= mterm_in;
      rd_addr_ff    <= rd_addr_in;
      rd_cnt_ff     <= rd_cnt_in;
      bit_cnt_ff    <= bit_cnt_in;
      rsp_net_ff    <= rsp_net_in;
      rsp_weight_ff <= rsp_weight_in;
      rsp_stable_ff <= rsp_stable_in;
   end

endmodule
